// File: src/dlefd_pkg.sv
// ----------------------------------------------------------------------------
// DLE frame deframer package
// Shared types, codes and the byte-wide CRC-16/XMODEM update.
// ----------------------------------------------------------------------------
`default_nettype none

package dlefd_pkg;

  // Framing phase of the receiver.
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_BODY
  } phase_t;

  // End of frame status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CRC         = 3'd1,
    ST_LENGTH      = 3'd2,
    ST_ADDRESS     = 3'd3,
    ST_PAYLOAD_LEN = 3'd4,
    ST_OVERSIZE    = 3'd5
  } status_t;

  // Configuration register map.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RAW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INFO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ADDR = 2'd2;

  localparam logic [9:0] MAX_RAW_RESET  = 10'd300;
  localparam logic [9:0] MAX_INFO_RESET = 10'd128;
  localparam logic [3:0] MAX_ADDR_RESET = 4'd6;

  // Framing characters.
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Width for header offset and length comparisons.
  localparam int CMP_W = 17;

  localparam logic [9:0] PAYLOAD_LEN_MAX = 10'h3FF;

  // Per-frame parse state.
  typedef struct packed {
    logic [15:0] running_crc;
    logic [15:0] tail_history;
    logic [15:0] info_length;
    logic [7:0]  origin_len;
    logic [7:0]  goal_len;
    logic [7:0]  origin_port;
    logic [7:0]  goal_port;
    logic [7:0]  mode_code;
    logic [7:0]  command_code;
    logic        addr_error;
  } frame_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [7:0]  origin_port;
    logic [7:0]  goal_port;
    logic [7:0]  mode_code;
    logic [7:0]  command_code;
    logic [9:0]  payload_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
  } result_t;

  // CRC-16/XMODEM over one byte, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: src/dlefd_absorb.sv
// ----------------------------------------------------------------------------
// DLE frame deframer body byte absorber
// Folds one destuffed body byte into the frame state and flags payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module dlefd_absorb #(
  parameter int COUNT_BITS = 10
) (
  input  logic [COUNT_BITS-1:0] count,
  input  dlefd_pkg::frame_t     frame_in,
  input  logic [7:0]            rx_data,
  input  logic [9:0]            max_info_length,
  input  logic [3:0]            max_address_length,
  output logic [COUNT_BITS-1:0] count_next,
  output dlefd_pkg::frame_t     frame_next,
  output logic                  emit
);

  localparam int CW = dlefd_pkg::CMP_W;

  logic [CW-1:0] b;
  logic [CW-1:0] info;
  logic [CW-1:0] o;
  logic [CW-1:0] g;
  logic [CW-1:0] d;
  logic [CW-1:0] max_addr;

  assign b        = CW'(count);
  assign info     = CW'(frame_in.info_length);
  assign o        = CW'(frame_in.origin_len);
  assign g        = CW'(frame_in.goal_len);
  assign d        = CW'(rx_data);
  assign max_addr = CW'(max_address_length);

  always_comb begin
    frame_next = frame_in;
    emit       = 1'b0;

    // The CRC covers the two length bytes and the rest of the info bytes.
    if (b < CW'(2) || b < info) begin
      frame_next.running_crc = dlefd_pkg::crc16_byte(frame_in.running_crc, rx_data);
    end
    frame_next.tail_history = {frame_in.tail_history[7:0], rx_data};

    if (b == CW'(0)) begin
      frame_next.info_length = {rx_data, 8'h00};
    end else if (b == CW'(1)) begin
      frame_next.info_length = {frame_in.info_length[15:8], rx_data};
    end else if (b == CW'(2)) begin
      frame_next.origin_port = rx_data;
    end else if (b == CW'(3)) begin
      frame_next.origin_len = rx_data;
      if (d > max_addr || CW'(6) + d > info) begin
        frame_next.addr_error = 1'b1;
      end
    end else if (!frame_in.addr_error) begin
      if (b == o + CW'(4)) begin
        frame_next.goal_port = rx_data;
      end else if (b == o + CW'(5)) begin
        frame_next.goal_len = rx_data;
        if (d > max_addr || CW'(8) + o + d > info) begin
          frame_next.addr_error = 1'b1;
        end
      end else if (b == o + g + CW'(6)) begin
        frame_next.mode_code = rx_data;
      end else if (b == o + g + CW'(7)) begin
        frame_next.command_code = rx_data;
      end else if (b >= o + g + CW'(8) && b < info &&
                   info >= CW'(8) && info <= CW'(max_info_length)) begin
        emit = 1'b1;
      end
    end

    count_next = (count == {COUNT_BITS{1'b1}}) ? count : count + 1'b1;
  end

endmodule

`default_nettype wire

// File: src/dlefd_out_buf.sv
// ----------------------------------------------------------------------------
// DLE frame deframer result buffer
// Output register with a skid entry, so the input side sees a registered ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dlefd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  dlefd_pkg::result_t push_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output dlefd_pkg::result_t out_data
);

  logic               main_valid;
  logic               skid_valid;
  dlefd_pkg::result_t skid_data;
  logic               main_free;

  assign main_free = !main_valid || out_ready;
  assign full      = skid_valid;
  assign out_valid = main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      out_data <= skid_valid ? skid_data : push_data;
      if (skid_valid && push) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/dle_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// DLE frame deframer with CRC-16/XMODEM check
// Takes one raw byte per transfer and accepts a new byte every cycle while the
// result buffer is not full. A result is loaded into the output register (or the
// skid entry when that register is stalled) at the edge of the transfer that pushes it.
// Output holds two results (register plus skid entry); ready is registered.
// Synchronous reset: hunting for a head, limits back to 300, 128 and 6.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_frame_deframer_crc16 #(
  parameter int COUNT_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  // Raw byte input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        rx_byte,
  // Result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output logic [7:0]                        data_byte,
  output logic [2:0]                        status,
  output logic [7:0]                        origin_port,
  output logic [7:0]                        goal_port,
  output logic [7:0]                        mode_code,
  output logic [7:0]                        command_code,
  output logic [9:0]                        payload_length,
  output logic [15:0]                       crc_received,
  output logic [15:0]                       crc_computed,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dlefd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dlefd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Width used to compare the raw count with the 10-bit limit.
  localparam int RW = (COUNT_BITS > 10) ? COUNT_BITS : 10;
  localparam int CW = dlefd_pkg::CMP_W;

  // Configuration registers.
  logic [9:0] max_raw_length;
  logic [9:0] max_info_length;
  logic [3:0] max_address_length;

  // Control state.
  dlefd_pkg::phase_t     phase;
  dlefd_pkg::phase_t     phase_next;
  logic                  dle_pending;
  logic                  dle_pending_next;
  logic [COUNT_BITS-1:0] raw_count;
  logic [COUNT_BITS-1:0] raw_count_next;
  logic [COUNT_BITS-1:0] body_count;
  logic [COUNT_BITS-1:0] body_count_next;
  logic                  held_valid;
  logic                  held_valid_next;

  // Frame payload state.
  dlefd_pkg::frame_t     frame;
  dlefd_pkg::frame_t     frame_next;
  logic [7:0]            held_byte;
  logic [7:0]            held_byte_next;

  // Handshake and decode.
  logic                  in_fire;
  logic                  buf_full;
  logic                  in_body;
  logic                  abort;
  logic                  end_frame;
  logic                  start;
  logic                  do_a;
  logic                  do_b;
  logic                  e1;
  logic                  e2;
  logic [7:0]            a_byte;

  // Absorber chain: the first stage takes the lone or stuffed DLE (or a plain
  // byte), the second stage the byte that follows a lone DLE.
  logic [COUNT_BITS-1:0] a_count;
  dlefd_pkg::frame_t     a_frame;
  logic                  a_emit;
  logic [COUNT_BITS-1:0] b_count;
  dlefd_pkg::frame_t     b_frame;
  logic                  b_emit;

  // Result path.
  logic                  res_valid;
  dlefd_pkg::result_t    res;
  dlefd_pkg::result_t    out_data;
  logic [9:0]            hdr_len;
  logic [15:0]           pl_diff;
  logic [9:0]            pl_len;
  dlefd_pkg::status_t    end_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = !buf_full;
  assign in_fire   = in_valid && in_ready;

  assign in_body   = in_fire && (phase == dlefd_pkg::PH_BODY);
  // A body byte arriving once the raw limit is reached ends the frame.
  assign abort     = in_body && (RW'(raw_count) >= RW'(max_raw_length));
  assign end_frame = in_body && !abort && dle_pending && (rx_byte == dlefd_pkg::CH_ETX);
  assign start     = in_fire && (phase == dlefd_pkg::PH_HEAD) &&
                     (rx_byte == dlefd_pkg::CH_STX);

  // A DLE seen on its own arms the pending flag; after it, DLE is a stuffed
  // data byte, ETX ends the frame and anything else gives DLE plus that byte.
  assign do_a = in_body && !abort &&
                (dle_pending ? (rx_byte != dlefd_pkg::CH_ETX)
                             : (rx_byte != dlefd_pkg::CH_DLE));
  assign do_b = in_body && !abort && dle_pending &&
                (rx_byte != dlefd_pkg::CH_DLE) && (rx_byte != dlefd_pkg::CH_ETX);
  assign a_byte = dle_pending ? dlefd_pkg::CH_DLE : rx_byte;
  assign e1 = do_a && a_emit;
  assign e2 = do_b && b_emit;

  dlefd_absorb #(
    .COUNT_BITS(COUNT_BITS)
  ) u_absorb_a (
    .count              (body_count),
    .frame_in           (frame),
    .rx_data            (a_byte),
    .max_info_length    (max_info_length),
    .max_address_length (max_address_length),
    .count_next         (a_count),
    .frame_next         (a_frame),
    .emit               (a_emit)
  );

  dlefd_absorb #(
    .COUNT_BITS(COUNT_BITS)
  ) u_absorb_b (
    .count              (a_count),
    .frame_in           (a_frame),
    .rx_data            (rx_byte),
    .max_info_length    (max_info_length),
    .max_address_length (max_address_length),
    .count_next         (b_count),
    .frame_next         (b_frame),
    .emit               (b_emit)
  );

  // Payload length from the header, clamped to the field range.
  assign hdr_len = 10'd8 + 10'(frame.origin_len) + 10'(frame.goal_len);
  assign pl_diff = frame.info_length - 16'(hdr_len);
  always_comb begin
    if (frame.info_length < 16'(hdr_len)) begin
      pl_len = '0;
    end else if (pl_diff > 16'(dlefd_pkg::PAYLOAD_LEN_MAX)) begin
      pl_len = dlefd_pkg::PAYLOAD_LEN_MAX;
    end else begin
      pl_len = pl_diff[9:0];
    end
  end

  // Status priority: length, then CRC, then address.
  always_comb begin
    if (frame.info_length < 16'd8 || frame.info_length > 16'(max_info_length) ||
        CW'(body_count) != CW'(frame.info_length) + CW'(2)) begin
      end_status = dlefd_pkg::ST_LENGTH;
    end else if (frame.running_crc != frame.tail_history) begin
      end_status = dlefd_pkg::ST_CRC;
    end else if (frame.addr_error) begin
      end_status = dlefd_pkg::ST_ADDRESS;
    end else begin
      end_status = dlefd_pkg::ST_OK;
    end
  end

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (phase)
        dlefd_pkg::PH_HUNT: begin
          if (rx_byte == dlefd_pkg::CH_DLE) begin
            phase_next = dlefd_pkg::PH_HEAD;
          end
        end
        dlefd_pkg::PH_HEAD: begin
          if (rx_byte == dlefd_pkg::CH_STX) begin
            phase_next = dlefd_pkg::PH_BODY;
          end else if (rx_byte != dlefd_pkg::CH_DLE) begin
            phase_next = dlefd_pkg::PH_HUNT;
          end
        end
        dlefd_pkg::PH_BODY: begin
          if (abort || end_frame) begin
            phase_next = dlefd_pkg::PH_HUNT;
          end
        end
        default: phase_next = dlefd_pkg::PH_HUNT;
      endcase
    end
  end

  // Datapath, held byte and result.
  always_comb begin
    dle_pending_next = dle_pending;
    raw_count_next   = raw_count;
    body_count_next  = body_count;
    frame_next       = frame;
    held_valid_next  = held_valid;
    held_byte_next   = held_byte;
    res_valid        = 1'b0;
    res              = '0;

    if (start) begin
      dle_pending_next = 1'b0;
      raw_count_next   = COUNT_BITS'(2);
      body_count_next  = '0;
      frame_next       = '0;
    end

    if (in_body && !abort) begin
      if (raw_count != {COUNT_BITS{1'b1}}) begin
        raw_count_next = raw_count + 1'b1;
      end
      dle_pending_next = !dle_pending && (rx_byte == dlefd_pkg::CH_DLE);
    end

    if (do_b) begin
      frame_next      = b_frame;
      body_count_next = b_count;
    end else if (do_a) begin
      frame_next      = a_frame;
      body_count_next = a_count;
    end

    if (in_fire) begin
      held_valid_next = 1'b0;
      if (abort) begin
        // Oversize: status only, and any held payload byte is dropped.
        res_valid  = 1'b1;
        res.kind   = 1'b1;
        res.status = dlefd_pkg::ST_OVERSIZE;
      end else if (end_frame) begin
        res_valid          = 1'b1;
        res.kind           = 1'b1;
        res.status         = end_status;
        res.origin_port    = frame.origin_port;
        res.goal_port      = frame.goal_port;
        res.mode_code      = frame.mode_code;
        res.command_code   = frame.command_code;
        res.payload_length = pl_len;
        res.crc_received   = frame.tail_history;
        res.crc_computed   = frame.running_crc;
      end else begin
        // Up to two payload bytes are ready in one step: the first goes out,
        // the second waits in the hold for the next transfer.
        res_valid     = held_valid || e1 || e2;
        res.data_byte = held_valid ? held_byte : (e1 ? a_byte : rx_byte);
        if ((held_valid && (e1 || e2)) || (e1 && e2)) begin
          held_valid_next = 1'b1;
          held_byte_next  = (held_valid && e1) ? a_byte : rx_byte;
        end
      end
    end
  end

  dlefd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign kind           = out_data.kind;
  assign data_byte      = out_data.data_byte;
  assign status         = out_data.status;
  assign origin_port    = out_data.origin_port;
  assign goal_port      = out_data.goal_port;
  assign mode_code      = out_data.mode_code;
  assign command_code   = out_data.command_code;
  assign payload_length = out_data.payload_length;
  assign crc_received   = out_data.crc_received;
  assign crc_computed   = out_data.crc_computed;

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= dlefd_pkg::PH_HUNT;
      dle_pending        <= 1'b0;
      raw_count          <= '0;
      body_count         <= '0;
      held_valid         <= 1'b0;
      max_raw_length     <= dlefd_pkg::MAX_RAW_RESET;
      max_info_length    <= dlefd_pkg::MAX_INFO_RESET;
      max_address_length <= dlefd_pkg::MAX_ADDR_RESET;
    end else begin
      phase       <= phase_next;
      dle_pending <= dle_pending_next;
      raw_count   <= raw_count_next;
      body_count  <= body_count_next;
      held_valid  <= held_valid_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dlefd_pkg::REG_MAX_RAW:  max_raw_length     <= cfg_data;
          dlefd_pkg::REG_MAX_INFO: max_info_length    <= cfg_data;
          dlefd_pkg::REG_MAX_ADDR: max_address_length <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // Frame contents and the held byte need no reset: a new frame clears the frame, held_valid guards the byte.
  always_ff @(posedge clk) begin
    frame     <= frame_next;
    held_byte <= held_byte_next;
  end

endmodule

`default_nettype wire
